>>> src/modular_inverse_defines.svh
// ----------------------------------------------------------------------------
// modular_inverse_defines
// Assertion helpers for the modular inverse block.
// ----------------------------------------------------------------------------
// The asserting module must have i_clk and i_rst_n in scope.
`ifndef MODULAR_INVERSE_DEFINES_SVH
`define MODULAR_INVERSE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MODINV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MODINV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/modinv_pkg.sv
// ----------------------------------------------------------------------------
// modinv_pkg
// Shared constants for the modular inverse block.
// ----------------------------------------------------------------------------
package modinv_pkg;

    // default operand width
    localparam int MI_WIDTH = 32;

endpackage

>>> src/modinv_if.sv
// ----------------------------------------------------------------------------
// modinv_in_if / modinv_out_if
// Valid/ready channels for operand requests and inverse results.
// ----------------------------------------------------------------------------
interface modinv_in_if #(
    parameter int WIDTH = modinv_pkg::MI_WIDTH
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] value;
    logic [WIDTH-1:0] modulus;

    modport source (output valid, output value, output modulus, input ready);
    modport sink   (input valid, input value, input modulus, output ready);
endinterface

interface modinv_out_if #(
    parameter int WIDTH = modinv_pkg::MI_WIDTH
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] inverse;
    logic             found;

    modport source (output valid, output inverse, output found, input ready);
    modport sink   (input valid, input inverse, input found, output ready);
endinterface

>>> src/modular_inverse.sv
// ----------------------------------------------------------------------------
// modular_inverse
// Modular multiplicative inverse by the extended Euclidean algorithm.
// ----------------------------------------------------------------------------
// One request at a time. The value is first reduced by the modulus, then
// Euclid runs with each quotient found by shift-and-subtract long division;
// a single shared subtractor does the alignment compares, the division
// subtracts and the final sign fix-up, one operation per cycle. Each
// division doubles the divisor in ST_ALIGN while twice it still fits, takes
// one quotient bit per ST_SUB step, and ends its Euclid step in ST_CHECK.
// Quotients of one, as with consecutive Fibonacci operands, are the slowest
// case. A modulus below 2 gives its result the cycle after acceptance. The
// input is not ready while an item is in work or its result waits to be
// taken.
// ----------------------------------------------------------------------------
`include "modular_inverse_defines.svh"

module modular_inverse #(
    parameter int WIDTH = modinv_pkg::MI_WIDTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    modinv_in_if.sink      i_in,
    modinv_out_if.source   o_out
);

    localparam int SW = $clog2(WIDTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ALIGN = 3'd1;
    localparam logic [2:0] ST_SUB   = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_FINAL = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [WIDTH-1:0] r_r0, n_r0, r_r1, n_r1;    // remainders
    logic [WIDTH-1:0] r_u0, n_u0, r_u1, n_u1;    // coefficient magnitudes
    logic             r_neg0, n_neg0, r_neg1, n_neg1;
    logic [WIDTH-1:0] r_div, n_div;              // shifted divisor
    logic [WIDTH-1:0] r_ush, n_ush;              // shifted coefficient
    logic [SW-1:0]    r_shift, n_shift;
    logic             r_reduce, n_reduce;        // first pass: value mod modulus
    logic [WIDTH-1:0] r_mod, n_mod;
    logic             r_out_valid, n_out_valid;
    logic [WIDTH-1:0] r_inv, n_inv;
    logic             r_found, n_found;

    // shared subtractor
    logic [WIDTH:0]   s_a, s_b;
    logic [WIDTH+1:0] s_diff;
    logic             s_borrow;
    logic [WIDTH-1:0] s_rem;
    logic [WIDTH-1:0] s_usum;
    logic             s_fit;
    logic             s_unorm;

    always_comb begin
        case (r_state)
            ST_ALIGN: begin
                s_a = {1'b0, r_r0};
                s_b = {r_div, 1'b0};
            end
            ST_FINAL: begin
                s_a = {1'b0, r_mod};
                s_b = {1'b0, r_u0};
            end
            default: begin
                s_a = {1'b0, r_r0};
                s_b = {1'b0, r_div};
            end
        endcase
    end

    assign s_diff   = {1'b0, s_a} - {1'b0, s_b};
    assign s_borrow = s_diff[WIDTH+1];
    assign s_fit    = !s_borrow;

    // step of long division: subtract when the shifted divisor fits
    assign s_rem  = s_fit ? s_diff[WIDTH-1:0] : r_r0;
    assign s_usum = (s_fit && !r_reduce) ? (r_u0 + r_ush) : r_u0;

    // coefficient magnitude reduced mod m is nonzero
    assign s_unorm = (r_u0 != '0) && (r_u0 != r_mod);

    assign i_in.ready    = (r_state == ST_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.inverse = r_inv;
    assign o_out.found   = r_found;

    always_comb begin
        n_state     = r_state;
        n_r0        = r_r0;
        n_r1        = r_r1;
        n_u0        = r_u0;
        n_u1        = r_u1;
        n_neg0      = r_neg0;
        n_neg1      = r_neg1;
        n_div       = r_div;
        n_ush       = r_ush;
        n_shift     = r_shift;
        n_reduce    = r_reduce;
        n_mod       = r_mod;
        n_out_valid = r_out_valid;
        n_inv       = r_inv;
        n_found     = r_found;

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.modulus < WIDTH'(2)) begin
                        n_inv       = '0;
                        n_found     = 1'b0;
                        n_out_valid = 1'b1;
                        n_state     = ST_OUT;
                    end else begin
                        n_r0     = i_in.value;
                        n_r1     = i_in.modulus;
                        n_mod    = i_in.modulus;
                        n_div    = i_in.modulus;
                        n_ush    = '0;
                        n_shift  = '0;
                        n_reduce = 1'b1;
                        n_state  = ST_ALIGN;
                    end
                end
            end

            ST_ALIGN: begin
                // grow the divisor while twice it still fits
                if (s_fit) begin
                    n_div   = {r_div[WIDTH-2:0], 1'b0};
                    n_ush   = {r_ush[WIDTH-2:0], 1'b0};
                    n_shift = r_shift + SW'(1);
                end else begin
                    n_state = ST_SUB;
                end
            end

            ST_SUB: begin
                if (r_shift == '0) begin
                    if (r_reduce) begin
                        n_r0     = r_mod;
                        n_r1     = s_rem;
                        n_u0     = '0;
                        n_u1     = {{(WIDTH-1){1'b0}}, 1'b1};
                        n_neg0   = 1'b0;
                        n_neg1   = 1'b0;
                        n_reduce = 1'b0;
                    end else begin
                        n_r0   = r_r1;
                        n_r1   = s_rem;
                        n_u0   = r_u1;
                        n_u1   = s_usum;
                        n_neg0 = r_neg1;
                        n_neg1 = !r_neg1;
                    end
                    n_state = ST_CHECK;
                end else begin
                    n_r0    = s_rem;
                    n_u0    = s_usum;
                    n_div   = {1'b0, r_div[WIDTH-1:1]};
                    n_ush   = {1'b0, r_ush[WIDTH-1:1]};
                    n_shift = r_shift - SW'(1);
                end
            end

            ST_CHECK: begin
                if (r_r1 == '0) begin
                    n_state = ST_FINAL;
                end else begin
                    n_div   = r_r1;
                    n_ush   = r_u1;
                    n_shift = '0;
                    n_state = ST_ALIGN;
                end
            end

            ST_FINAL: begin
                // gcd must be one; negative coefficient becomes m - u
                if ((r_r0 == {{(WIDTH-1){1'b0}}, 1'b1}) && s_unorm) begin
                    n_found = 1'b1;
                    n_inv   = r_neg0 ? s_diff[WIDTH-1:0] : r_u0;
                end else begin
                    n_found = 1'b0;
                    n_inv   = '0;
                end
                n_out_valid = 1'b1;
                n_state     = ST_OUT;
            end

            ST_OUT: begin
                if (o_out.ready) begin
                    n_out_valid = 1'b0;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_out_valid = 1'b0;
                n_state     = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_reduce    <= 1'b0;
            r_shift     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_reduce    <= n_reduce;
            r_shift     <= n_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r0    <= n_r0;
        r_r1    <= n_r1;
        r_u0    <= n_u0;
        r_u1    <= n_u1;
        r_neg0  <= n_neg0;
        r_neg1  <= n_neg1;
        r_div   <= n_div;
        r_ush   <= n_ush;
        r_mod   <= n_mod;
        r_inv   <= n_inv;
        r_found <= n_found;
    end

    `MODINV_ASSERT_NOW(a_no_overlap, i_in.ready, !o_out.valid,
        "input ready while a result is pending")
    `MODINV_ASSERT_NOW(a_found_nonzero, o_out.valid && o_out.found,
        o_out.inverse != '0, "found result with zero inverse")
    `MODINV_ASSERT_NOW(a_inv_range, o_out.valid && o_out.found && (r_state == ST_OUT),
        o_out.inverse < r_mod, "inverse not below modulus")
    `MODINV_ASSERT_NEXT(a_small_mod, i_in.valid && i_in.ready && (i_in.modulus < WIDTH'(2)),
        o_out.valid && !o_out.found, "small modulus not rejected")
    `MODINV_ASSERT_NOW(a_check_shift, r_state == ST_CHECK, r_shift == '0,
        "division left with nonzero shift")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for modular_inverse: a directed table of corner operands, then
// random requests in three idling phases, scored against the expectation
// given in a table row or else against a behavioral extended-Euclid predictor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int W                = modinv_pkg::MI_WIDTH;
    localparam int NUM_DIRECTED     = 24;
    localparam int RANDOM_PER_PHASE = 434;
    localparam int DRAIN_CYCLES     = 8 * W + 32;
    localparam int CYCLE_LIMIT      = 2_000_000;

    typedef struct packed {
        logic [W-1:0] inverse;
        logic         found;
    } t_inv_result;

    typedef struct packed {
        logic [W-1:0] value;
        logic [W-1:0] modulus;
        logic         typed;    // expectation given in the row
        logic [W-1:0] inverse;
        logic         found;
    } t_stim_row;

    // Corner operands; rows with typed = 0 go through the predictor.
    t_stim_row directed_rows [NUM_DIRECTED] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
        '{32'h0000_0005, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
        '{32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0000_0000, 1'b0},
        '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0000, 1'b0},
        '{32'h0000_0000, 32'h0000_0002, 1'b1, 32'h0000_0000, 1'b0},
        '{32'h0000_0001, 32'h0000_0002, 1'b1, 32'h0000_0001, 1'b1},
        '{32'h0000_0003, 32'h0000_0002, 1'b1, 32'h0000_0001, 1'b1},
        '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001, 1'b1},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
        '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFE, 1'b1},
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
        '{32'h0000_0002, 32'h0000_0004, 1'b1, 32'h0000_0000, 1'b0},
        '{32'h0000_0003, 32'h0000_0007, 1'b1, 32'h0000_0005, 1'b1},
        '{32'h0000_0006, 32'h0000_0009, 1'b1, 32'h0000_0000, 1'b0},
        '{32'h0000_0007, 32'h0000_0007, 1'b1, 32'h0000_0000, 1'b0},
        '{32'h0000_0002, 32'hFFFF_FFFE, 1'b1, 32'h0000_0000, 1'b0},
        '{32'h0000_0001, 32'h8000_0000, 1'b1, 32'h0000_0001, 1'b1},
        '{32'h0000_000A, 32'h0000_0011, 1'b0, 32'h0000_0000, 1'b0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFB, 1'b0, 32'h0000_0000, 1'b0},
        '{32'h1234_5678, 32'hFFFF_FFFB, 1'b0, 32'h0000_0000, 1'b0},
        '{32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
        // consecutive Fibonacci numbers: longest Euclid chain at this width
        '{32'h6D73_E55F, 32'hB11924E1, 1'b0, 32'h0000_0000, 1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    modinv_in_if  #(.WIDTH(W)) req_if ();
    modinv_out_if #(.WIDTH(W)) res_if ();

    modular_inverse #(.WIDTH(W)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_inv_result expected_inverses [$];
    int          src_idle_pct;
    int          snk_idle_pct;
    int          mismatch_count  = 0;
    int          requests_sent   = 0;
    int          results_checked = 0;
    int          found_count     = 0;
    int          cycle_count     = 0;

    // Extended Euclid with coefficient magnitude and sign tracked apart.
    function automatic t_inv_result predict_inverse(logic [W-1:0] a, logic [W-1:0] m);
        logic [2*W-1:0] r0, r1, r2, q, u0, u1, u2;
        logic           n0, n1, n2;
        t_inv_result    res;
        res.inverse = '0;
        res.found   = 1'b0;
        if (m < 2)
            return res;
        r0 = {{W{1'b0}}, m};
        r1 = {{W{1'b0}}, a % m};
        u0 = '0;
        u1 = {{(2*W-1){1'b0}}, 1'b1};
        n0 = 1'b0;
        n1 = 1'b0;
        while (r1 != 0) begin
            q  = r0 / r1;
            r2 = r0 - q * r1;
            u2 = u0 + q * u1;
            n2 = !n1;
            r0 = r1;
            r1 = r2;
            u0 = u1;
            u1 = u2;
            n0 = n1;
            n1 = n2;
        end
        if (r0 == 1) begin
            u0 = u0 % m;
            if (n0 && u0 != 0)
                u0 = m - u0;
            if (u0 != 0) begin
                res.inverse = u0[W-1:0];
                res.found   = 1'b1;
            end
        end
        return res;
    endfunction

    // Present one request, with an optional idle gap first, and record its
    // expectation once it is accepted.
    task automatic issue_request(logic [W-1:0] v, logic [W-1:0] m,
                                 logic typed, t_inv_result typed_res);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        req_if.valid   <= 1'b1;
        req_if.value   <= v;
        req_if.modulus <= m;
        do @(posedge i_clk); while (!req_if.ready);
        expected_inverses.push_back(typed ? typed_res : predict_inverse(v, m));
        requests_sent++;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $time,
                     expected_inverses.size());
            $display("modular_inverse regression: fail");
            $finish;
        end
    end

    // Result side: score accepted results, then pick next-cycle ready.
    always @(posedge i_clk) begin
        t_inv_result exp_res;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_inverses.size() == 0) begin
                    $display("%0t unexpected result: expected none, got inverse %h found %b",
                             $time, res_if.inverse, res_if.found);
                    mismatch_count++;
                end else begin
                    exp_res = expected_inverses.pop_front();
                    results_checked++;
                    if (exp_res.found)
                        found_count++;
                    if (res_if.inverse !== exp_res.inverse) begin
                        $display("%0t inverse mismatch: expected %h, actual %h",
                                 $time, exp_res.inverse, res_if.inverse);
                        mismatch_count++;
                    end
                    if (res_if.found !== exp_res.found) begin
                        $display("%0t found mismatch: expected %b, actual %b",
                                 $time, exp_res.found, res_if.found);
                        mismatch_count++;
                    end
                end
            end
            res_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    initial begin
        logic [W-1:0] v, m, g, fa, fb, ft;
        int           kind, k;
        t_inv_result  typed_res;

        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.value    = '0;
        req_if.modulus  = '0;
        src_idle_pct    = 27;
        snk_idle_pct    = 50;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            typed_res.inverse = directed_rows[i].inverse;
            typed_res.found   = directed_rows[i].found;
            issue_request(directed_rows[i].value, directed_rows[i].modulus,
                          directed_rows[i].typed, typed_res);
        end

        typed_res = '0;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin src_idle_pct = 27; snk_idle_pct = 50; end
                1: begin src_idle_pct = 50; snk_idle_pct = 27; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                kind = $urandom_range(0, 99);
                v    = $urandom;
                m    = $urandom;
                if (kind < 5) begin
                    m = $urandom_range(0, 1);
                end else if (kind < 20) begin
                    m = $urandom_range(2, 64);
                    if ($urandom_range(0, 1))
                        v = $urandom_range(0, 200);
                end else if (kind < 45) begin
                    // full-range operands, already random
                end else if (kind < 55) begin
                    case ($urandom_range(0, 4))
                        0: m = 32'hFFFF_FFFB;
                        1: m = 32'hFFFF_FFEF;
                        2: m = 32'h7FFF_FFFF;
                        3: m = 32'd65521;
                        default: m = 32'd251;
                    endcase
                end else if (kind < 65) begin
                    m = 32'h1 << $urandom_range(1, 31);
                end else if (kind < 75) begin
                    // shared factor, never invertible
                    g = $urandom_range(2, 1000);
                    m = g * $urandom_range(1, 32'hFFFF_FFFF / g);
                    v = g * $urandom_range(0, 32'hFFFF_FFFF / g);
                end else if (kind < 85) begin
                    case ($urandom_range(0, 5))
                        0: v = '0;
                        1: v = 1;
                        2: v = m - 1;
                        3: v = m;
                        4: v = m + 1;
                        default: v = '1;
                    endcase
                end else if (kind < 93) begin
                    // neighboring Fibonacci numbers drive the deepest chains
                    k  = $urandom_range(20, 46);
                    fa = 0;
                    fb = 1;
                    for (int j = 0; j < k; j++) begin
                        ft = fa + fb;
                        fa = fb;
                        fb = ft;
                    end
                    v = $urandom_range(0, 1) ? fa : fb;
                    m = (v == fa) ? fb : fa;
                end else begin
                    m = m | 32'h8000_0000;
                    v = v | 32'h8000_0000;
                end
                issue_request(v, m, 1'b0, typed_res);
            end
        end
        req_if.valid <= 1'b0;

        while (expected_inverses.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests (%0d from the corner table) over three idling phases",
                 requests_sent, NUM_DIRECTED);
        $display("%0d results scored, %0d invertible, %0d mismatches",
                 results_checked, found_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("modular_inverse regression: pass");
        end else begin
            $display("modular_inverse regression: fail");
        end
        $finish;
    end

endmodule
